[sv/rc5_pkg.sv]
// Package: shared constants and types for the RC5-32 engine.
package rc5_pkg;

  localparam int MAX_ROUNDS_DEF    = 32;
  localparam int MAX_KEY_BYTES_DEF = 64;

  localparam logic [31:0] RC5_P = 32'hB7E15163;
  localparam logic [31:0] RC5_Q = 32'h9E3779B9;

  localparam int ROUND_W = 6;
  localparam int KLEN_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EXPAND  = 2'd1,
    REQ_ENCRYPT = 2'd2,
    REQ_DECRYPT = 2'd3
  } req_t;

  // Datapath operation selected by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT_WR,
    OP_MIX,
    OP_ENC_LOAD,
    OP_ENC_ROUND,
    OP_DEC_ROUND,
    OP_DEC_FINAL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        rk_rd_en;
    logic [7:0]  rk_rd_addr;
    logic        clr_ab;
    logic        half;   // which half of the round is processed
    logic        key_clear;
  } rc5_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} << s;
    return d[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} >> s;
    return d[31:0];
  endfunction

endpackage

[sv/rc5_if.sv]
// Interfaces: request, result and configuration channels.
interface rc5_req_if;
  import rc5_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  key_index;
  logic [7:0]  key_byte;
  logic [31:0] block_low;
  logic [31:0] block_high;
  modport source (output valid, req_type, key_index, key_byte, block_low, block_high,
                  input ready);
  modport sink (input valid, req_type, key_index, key_byte, block_low, block_high,
                output ready);
endinterface

interface rc5_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_low;
  logic [31:0] out_high;
  modport source (output valid, out_low, out_high, input ready);
  modport sink (input valid, out_low, out_high, output ready);
endinterface

interface rc5_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/rc5_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
module rc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 66
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem_r[rd_addr];
  end
endmodule

[sv/rc5_datapath.sv]
// Datapath: key word store, round key RAM and the A/B mixing registers.
module rc5_datapath
  import rc5_pkg::*;
#(
  parameter int MAX_ROUNDS    = MAX_ROUNDS_DEF,
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  parameter int RK_DEPTH      = 2 * MAX_ROUNDS + 2,
  parameter int RK_AW         = $clog2(RK_DEPTH),
  parameter int KW_DEPTH      = (MAX_KEY_BYTES + 3) / 4,
  parameter int KW_AW         = (KW_DEPTH > 1) ? $clog2(KW_DEPTH) : 1,
  parameter int KB_W          = $clog2(MAX_KEY_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rc5_cmd_t          cmd,
  input  logic [RK_AW-1:0]  rk_wr_addr,
  input  logic [KW_AW-1:0]  kw_idx,
  input  logic [KB_W-1:0]   key_len,
  // key byte load
  input  logic              load_en,
  input  logic [5:0]        load_idx,
  input  logic [7:0]        load_byte,
  // block capture
  input  logic              blk_en,
  input  logic [31:0]       blk_low,
  input  logic [31:0]       blk_high,
  output logic [31:0]       a_out,
  output logic [31:0]       b_out
);
  logic [31:0] kw_r [KW_DEPTH];
  logic [31:0] a_r, b_r;
  logic [31:0] init_r;
  logic [31:0] rk_rd;
  logic        rk_we;
  logic [31:0] rk_wd;
  logic [31:0] kw_masked, mix_a, mix_b, sum_ab;

  rc5_ram #(.WIDTH(32), .DEPTH(RK_DEPTH)) u_rk (
    .clk(clk), .wr_en(rk_we), .wr_addr(rk_wr_addr), .wr_data(rk_wd),
    .rd_en(cmd.rk_rd_en), .rd_addr(cmd.rk_rd_addr[RK_AW-1:0]), .rd_data(rk_rd)
  );

  always_comb begin
    kw_masked = kw_r[kw_idx];
    mix_a  = rotl(rk_rd + a_r + b_r, 5'd3);
    sum_ab = mix_a + b_r;
    mix_b  = rotl(kw_masked + sum_ab, sum_ab[4:0]);
  end

  always_comb begin
    rk_we = 1'b0;
    rk_wd = init_r;
    case (cmd.op)
      OP_INIT_WR: rk_we = 1'b1;
      OP_MIX: begin
        rk_we = 1'b1;
        rk_wd = mix_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < KW_DEPTH; w++) kw_r[w] <= '0;
    end else if (cmd.key_clear) begin
      for (int w = 0; w < KW_DEPTH; w++) kw_r[w] <= '0;
    end else if (cmd.clr_ab) begin
      // drop key bytes at or beyond the key length before mixing starts
      for (int w = 0; w < KW_DEPTH; w++) begin
        for (int k = 0; k < 4; k++) begin
          if ((w * 4 + k) >= 32'(key_len)) kw_r[w][8*k +: 8] <= 8'h00;
        end
      end
    end else if (cmd.op == OP_MIX) begin
      kw_r[kw_idx] <= mix_b;
    end else if (load_en && (32'(load_idx) < MAX_KEY_BYTES)) begin
      kw_r[load_idx[2 +: KW_AW]][8*load_idx[1:0] +: 8] <= load_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_INIT_WR) init_r <= init_r + RC5_Q;
    else if (cmd.clr_ab) init_r <= RC5_P;
    if (blk_en) begin
      a_r <= blk_low;
      b_r <= blk_high;
    end else if (cmd.clr_ab) begin
      a_r <= '0;
      b_r <= '0;
    end else begin
      case (cmd.op)
        OP_MIX: begin
          a_r <= mix_a;
          b_r <= mix_b;
        end
        OP_ENC_LOAD: begin
          if (cmd.half) b_r <= b_r + rk_rd;
          else a_r <= a_r + rk_rd;
        end
        OP_ENC_ROUND: begin
          if (cmd.half) b_r <= rotl(b_r ^ a_r, a_r[4:0]) + rk_rd;
          else a_r <= rotl(a_r ^ b_r, b_r[4:0]) + rk_rd;
        end
        OP_DEC_ROUND: begin
          if (cmd.half) b_r <= rotr(b_r - rk_rd, a_r[4:0]) ^ a_r;
          else a_r <= rotr(a_r - rk_rd, b_r[4:0]) ^ b_r;
        end
        OP_DEC_FINAL: begin
          if (cmd.half) b_r <= b_r - rk_rd;
          else a_r <= a_r - rk_rd;
        end
        default: ;
      endcase
    end
  end

  assign a_out = a_r;
  assign b_out = b_r;
endmodule

[sv/rc5_ctrl.sv]
// Controller: sequences key loads, expansion and block rounds.
module rc5_ctrl
  import rc5_pkg::*;
#(
  parameter int MAX_ROUNDS    = MAX_ROUNDS_DEF,
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  parameter int RK_DEPTH      = 2 * MAX_ROUNDS + 2,
  parameter int RK_AW         = $clog2(RK_DEPTH),
  parameter int KW_DEPTH      = (MAX_KEY_BYTES + 3) / 4,
  parameter int KW_AW         = (KW_DEPTH > 1) ? $clog2(KW_DEPTH) : 1,
  parameter int KB_W          = $clog2(MAX_KEY_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [1:0]        in_type,
  input  logic [ROUND_W-1:0] round_cfg,
  input  logic [KLEN_W-1:0]  klen_cfg,
  input  logic              out_busy,
  output logic              idle,
  output logic              res_load,
  output rc5_cmd_t          cmd,
  output logic [RK_AW-1:0]  rk_wr_addr,
  output logic [KW_AW-1:0]  kw_idx,
  output logic [KB_W-1:0]   key_len
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_MIXRD = 6'b000100,
    S_MIX   = 6'b001000,
    S_BLK   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam int CNT_W = $clog2(3 * (RK_DEPTH > KW_DEPTH ? RK_DEPTH : KW_DEPTH) + 1);

  state_t state_r, state_nxt;
  logic [RK_AW-1:0] i_r, i_nxt;
  logic [KW_AW-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [7:0]       step_r, step_nxt;   // block half-step counter
  logic             dec_r, dec_nxt;
  logic [7:0]       r_eff;
  logic [RK_AW-1:0] t_words;
  logic [KW_AW:0]   c_words;
  logic [7:0]       last_step;
  logic [7:0]       rd_addr;

  always_comb begin
    r_eff = 8'(round_cfg);
    if (r_eff == 8'd0) r_eff = 8'd1;
    if (32'(r_eff) > MAX_ROUNDS) r_eff = 8'(MAX_ROUNDS);
    key_len = KB_W'(klen_cfg);
    if (klen_cfg == '0) key_len = KB_W'(1);
    if (32'(klen_cfg) > MAX_KEY_BYTES) key_len = KB_W'(MAX_KEY_BYTES);
    t_words   = RK_AW'({r_eff, 1'b0} + 9'd2);
    c_words   = (KW_AW + 1)'((32'(key_len) + 3) >> 2);
    last_step = 8'({r_eff, 1'b0} + 9'd1);
  end

  // address of round key used by the next half step of a block
  always_comb begin
    if (dec_r) rd_addr = last_step - step_nxt;
    else rd_addr = step_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    n_nxt = n_r;
    step_nxt = step_r;
    dec_nxt = dec_r;
    cmd = '0;
    cmd.op = OP_NONE;
    res_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_type == REQ_EXPAND)) begin
          state_nxt = S_INIT;
          i_nxt = '0;
          cmd.clr_ab = 1'b1;
        end else if (in_fire && (in_type == REQ_ENCRYPT || in_type == REQ_DECRYPT)) begin
          state_nxt = S_BLK;
          dec_nxt = (in_type == REQ_DECRYPT);
          step_nxt = '0;
          cmd.rk_rd_en = 1'b1;
          cmd.rk_rd_addr = (in_type == REQ_DECRYPT) ? last_step : 8'd0;
        end
      end
      S_INIT: begin
        cmd.op = OP_INIT_WR;
        if (i_r == t_words - 1'b1) begin
          i_nxt = '0;
          j_nxt = '0;
          n_nxt = CNT_W'(3) * CNT_W'((32'(t_words) > 32'(c_words)) ? 32'(t_words)
                                                                  : 32'(c_words));
          state_nxt = S_MIXRD;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_MIXRD: begin
        cmd.rk_rd_en = 1'b1;
        cmd.rk_rd_addr = 8'(i_r);
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.op = OP_MIX;
        i_nxt = (i_r == t_words - 1'b1) ? '0 : i_r + 1'b1;
        j_nxt = (32'(j_r) == 32'(c_words) - 1) ? '0 : j_r + 1'b1;
        n_nxt = n_r - 1'b1;
        if (n_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
          cmd.key_clear = 1'b1;
        end else begin
          state_nxt = S_MIXRD;
        end
      end
      S_BLK: begin
        cmd.half = step_r[0] ^ dec_r;
        if (!dec_r) cmd.op = (step_r < 8'd2) ? OP_ENC_LOAD : OP_ENC_ROUND;
        else cmd.op = (step_r < last_step - 8'd1) ? OP_DEC_ROUND : OP_DEC_FINAL;
        if (step_r == last_step) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
          cmd.rk_rd_en = 1'b1;
          cmd.rk_rd_addr = rd_addr;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0;
      j_r <= '0;
      n_r <= '0;
      step_r <= '0;
      dec_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      n_r <= n_nxt;
      step_r <= step_nxt;
      dec_r <= dec_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);
  assign rk_wr_addr = i_r;
  assign kw_idx = j_r;
endmodule

[sv/rc5_32_block_cipher.sv]
// Top level: RC5-32 block cipher engine.
// A block runs its round work one half round per cycle (one round key RAM read
// port), then the controller hands the result to the output register once that
// register is free. In a key expansion, table init writes one entry per cycle,
// and each mixing step reads then writes the round key RAM. The output register
// lets the next item be accepted while a result waits.
module rc5_32_block_cipher
  import rc5_pkg::*;
#(
  parameter int MAX_ROUNDS    = MAX_ROUNDS_DEF,
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input logic clk,
  input logic rst_n,
  rc5_req_if.sink   in_ch,
  rc5_res_if.source out_ch,
  rc5_cfg_if.sink   cfg_ch
);
  localparam int RK_DEPTH = 2 * MAX_ROUNDS + 2;
  localparam int RK_AW    = $clog2(RK_DEPTH);
  localparam int KW_DEPTH = (MAX_KEY_BYTES + 3) / 4;
  localparam int KW_AW    = (KW_DEPTH > 1) ? $clog2(KW_DEPTH) : 1;
  localparam int KB_W     = $clog2(MAX_KEY_BYTES + 1);

  logic [ROUND_W-1:0] round_r;
  logic [KLEN_W-1:0]  klen_r;
  logic               idle, res_load, in_fire;
  rc5_cmd_t           cmd;
  logic [RK_AW-1:0]   rk_wr_addr;
  logic [KW_AW-1:0]   kw_idx;
  logic [KB_W-1:0]    key_len;
  logic [31:0]        a_val, b_val;
  logic               ov_r;
  logic [31:0]        lo_r, hi_r;

  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r <= ROUND_W'(12);
      klen_r  <= KLEN_W'(16);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROUND_COUNT: round_r <= cfg_ch.data[ROUND_W-1:0];
        REG_KEY_LENGTH:  klen_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  rc5_ctrl #(.MAX_ROUNDS(MAX_ROUNDS), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_type(in_ch.req_type),
    .round_cfg(round_r), .klen_cfg(klen_r), .out_busy(ov_r && !out_ch.ready),
    .idle(idle), .res_load(res_load), .cmd(cmd), .rk_wr_addr(rk_wr_addr),
    .kw_idx(kw_idx), .key_len(key_len)
  );

  rc5_datapath #(.MAX_ROUNDS(MAX_ROUNDS), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .rk_wr_addr(rk_wr_addr), .kw_idx(kw_idx),
    .key_len(key_len),
    .load_en(in_fire && in_ch.req_type == REQ_LOAD),
    .load_idx(in_ch.key_index), .load_byte(in_ch.key_byte),
    .blk_en(in_fire && (in_ch.req_type == REQ_ENCRYPT || in_ch.req_type == REQ_DECRYPT)),
    .blk_low(in_ch.block_low), .blk_high(in_ch.block_high),
    .a_out(a_val), .b_out(b_val)
  );

  // output register: hold until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (res_load) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      lo_r <= a_val;
      hi_r <= b_val;
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.out_low  = lo_r;
  assign out_ch.out_high = hi_r;

  a_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!ov_r || out_ch.ready))
    else $error("result loaded over an untaken transaction");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (in_ch.ready && out_ch.valid))
    else $error("controller not idle after result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_NONE) |-> !in_ch.ready)
    else $error("input accepted while datapath busy");
endmodule
